/* rtl/tlc_pkg.sv */
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared constants, register codes and trig tables of the thin-lens ray
// generator.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int COORD_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SCREEN_BITS_DEF = 12;

    localparam int REG_W     = 60;
    localparam int LENS_W    = 16;
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_BLADES = 9;
    localparam int BLADE_W    = 4;
    localparam int TRIG_W     = 16;
    localparam int XR_W       = 24;

    localparam int NORM_W     = 30;
    localparam int SUMSQ_W    = 62;
    localparam int ROOT_W     = 31;
    localparam int SQRT_STEPS = 31;
    localparam int DIR_W      = 16;
    localparam int DIR_FRAC   = 14;
    localparam int DIRN_W     = 45;
    localparam int DIRQ_W     = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_POS,
        CFG_LENS_SIZE,
        CFG_RIGHT_VEC,
        CFG_UP_VEC,
        CFG_CORNER_POINT,
        CFG_SCREEN_WIDTH,
        CFG_SCREEN_HEIGHT
    } t_cfg_idx;

    // Blade corner directions, Q1.14, 40 degrees apart
    function automatic logic signed [TRIG_W-1:0] cos_lut(input logic [BLADE_W-1:0] idx);
        logic signed [TRIG_W-1:0] val;
        case (idx)
            4'd0:    val = 16'sd16384;
            4'd1:    val = 16'sd12551;
            4'd2:    val = 16'sd2845;
            4'd3:    val = -16'sd8192;
            4'd4:    val = -16'sd15396;
            4'd5:    val = -16'sd15396;
            4'd6:    val = -16'sd8192;
            4'd7:    val = 16'sd2845;
            4'd8:    val = 16'sd12551;
            default: val = 16'sd16384;
        endcase
        return val;
    endfunction

    function automatic logic signed [TRIG_W-1:0] sin_lut(input logic [BLADE_W-1:0] idx);
        logic signed [TRIG_W-1:0] val;
        case (idx)
            4'd0:    val = 16'sd0;
            4'd1:    val = 16'sd10531;
            4'd2:    val = 16'sd16135;
            4'd3:    val = 16'sd14189;
            4'd4:    val = 16'sd5604;
            4'd5:    val = -16'sd5604;
            4'd6:    val = -16'sd14189;
            4'd7:    val = -16'sd16135;
            4'd8:    val = -16'sd10531;
            default: val = 16'sd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/tlc_smp_if.sv */
// ----------------------------------------------------------------------------
// tlc_smp_if
// Sample channel: pixel coordinate and four random fractions.
// ----------------------------------------------------------------------------
interface tlc_smp_if import tlc_pkg::*; #(
    parameter int SCREEN_BITS = SCREEN_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SCREEN_BITS-1:0] pixel_x;
    logic [SCREEN_BITS-1:0] pixel_y;
    logic [SAMPLE_BITS-1:0] rand_a;
    logic [SAMPLE_BITS-1:0] rand_b;
    logic [SAMPLE_BITS-1:0] rand_c;
    logic [SAMPLE_BITS-1:0] rand_d;

    modport source (output valid, pixel_x, pixel_y, rand_a, rand_b, rand_c, rand_d,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, rand_a, rand_b, rand_c, rand_d,
                  output ready);
endinterface

/* rtl/tlc_ray_if.sv */
// ----------------------------------------------------------------------------
// tlc_ray_if
// Ray channel: origin and unit direction.
// ----------------------------------------------------------------------------
interface tlc_ray_if import tlc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [DIR_W-1:0]      dir_x;
    logic signed [DIR_W-1:0]      dir_y;
    logic signed [DIR_W-1:0]      dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

/* rtl/tlc_delay.sv */
// ----------------------------------------------------------------------------
// tlc_delay
// Enabled shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module tlc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

/* rtl/tlc_udiv.sv */
// ----------------------------------------------------------------------------
// tlc_udiv
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlc_udiv #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [NUM_W-1:0] w_rem;
        logic [DEN_W-1:0] w_den;
        logic [QUO_W-1:0] w_quo;
        logic [CMP_W-1:0] w_sub;
        logic             w_ge;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_den = r_den[g-1];
            assign w_quo = r_quo[g-1];
        end

        assign w_sub = CMP_W'(w_den) << (QUO_W - 1 - g);
        assign w_ge  = CMP_W'(w_rem) >= w_sub;

        always_comb begin
            n_rem = w_ge ? NUM_W'(CMP_W'(w_rem) - w_sub) : w_rem;
            n_quo = w_quo;
            n_quo[QUO_W-1-g] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[g] <= n_quo;
            end
        end

        if (g < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_den[g] <= w_den;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
endmodule

/* rtl/tlc_isqrt.sv */
// ----------------------------------------------------------------------------
// tlc_isqrt
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tlc_isqrt import tlc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SUMSQ_W-1:0] i_n,
    output logic [ROOT_W-1:0]  o_root
);
    logic [SUMSQ_W-1:0] r_n [SQRT_STEPS];
    logic [SUMSQ_W-1:0] r_r [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_stage
        localparam logic [SUMSQ_W-1:0] STEP_BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * g);
        logic [SUMSQ_W-1:0] w_n;
        logic [SUMSQ_W-1:0] w_r;
        logic [SUMSQ_W:0]   w_try;
        logic               w_ge;

        if (g == 0) begin : g_first
            assign w_n = i_n;
            assign w_r = '0;
        end else begin : g_next
            assign w_n = r_n[g-1];
            assign w_r = r_r[g-1];
        end

        assign w_try = {1'b0, w_r} + {1'b0, STEP_BIT};
        assign w_ge  = {1'b0, w_n} >= w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[g] <= w_ge ? (w_r >> 1) + STEP_BIT : (w_r >> 1);
            end
        end

        if (g < SQRT_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[g] <= w_ge ? w_n - w_try[SUMSQ_W-1:0] : w_n;
                end
            end
        end
    end

    assign o_root = r_r[SQRT_STEPS-1][ROOT_W-1:0];
endmodule

/* rtl/thin_lens_camera_ray_generator.sv */
// ----------------------------------------------------------------------------
// thin_lens_camera_ray_generator
// Thin-lens camera with a nine-bladed polygonal aperture: one primary ray per
// pixel sample.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while no ray waits at the output, and returns
// one ray per sample, in order. The pipeline depth is set by the
// pixel-to-screen divides (one quotient bit per stage, SCREEN_BITS + 17
// stages), the 31-stage square root of the direction length and the 17-stage
// direction divide. The whole pipeline freezes while a ray waits at the
// output, so no transaction is lost or repeated; i_smp.ready is low only then.
// Write configuration registers only while the pipeline is empty. Origins
// saturate to signed Q10.10; directions are signed Q1.14, and a zero pointing
// vector gives a zero direction.
module thin_lens_camera_ray_generator import tlc_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    tlc_smp_if.sink              i_smp,
    tlc_ray_if.source            o_ray
);
    localparam int SB = SAMPLE_BITS;
    localparam int CB = COORD_BITS;
    localparam int SW = SCREEN_BITS;

    // screen fraction divide
    localparam int QU_W = SW + 17;
    localparam int NU_W = SW + SB + 17;
    localparam int DU_W = SIZE_W + SB;
    // lens path
    localparam int R2_W  = SB + 5;
    localparam int R3_W  = SB + 2;
    localparam int PRD_W = TRIG_W + R2_W;
    localparam int ACC_W = PRD_W + 1;
    localparam int LX_W  = XR_W + LENS_W + 1;
    localparam int OFF_W = CB + LX_W + 1;
    localparam int OS_W  = OFF_W - 22;
    // pixel point and direction
    localparam int PU_W  = QU_W + 1 + CB;
    localparam int PS_W  = PU_W + 2;
    localparam int PR_W  = PS_W - 16;
    localparam int PT_W  = PR_W + 1;
    localparam int D_W   = PT_W + 1;
    localparam int POS_W = $clog2(D_W);
    localparam int SQ_W  = 2 * NORM_W;
    // latency and side-data delays
    localparam int LAT     = QU_W + 58;
    localparam int D_ORG_A = QU_W - 3;
    localparam int D_ORG_B = 54;
    localparam int D_NORM  = 33;
    localparam int D_FLAG  = 51;

    localparam logic signed [R3_W-1:0] ONE    = R3_W'(2 ** SB);
    localparam logic signed [OS_W-1:0] SAT_HI = OS_W'(2 ** (CB - 1) - 1);
    localparam logic signed [OS_W-1:0] SAT_LO = OS_W'(-(2 ** (CB - 1)));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [REG_W-1:0]  r_cam, r_right, r_up, r_corner;
    logic [LENS_W-1:0] r_lens;
    logic [SIZE_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam    <= '0;
            r_right  <= '0;
            r_up     <= '0;
            r_corner <= '0;
            r_lens   <= '0;
            r_width  <= SIZE_W'(1);
            r_height <= SIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAMERA_POS:    r_cam    <= i_cfg_data;
                CFG_LENS_SIZE:     r_lens   <= i_cfg_data[LENS_W-1:0];
                CFG_RIGHT_VEC:     r_right  <= i_cfg_data;
                CFG_UP_VEC:        r_up     <= i_cfg_data;
                CFG_CORNER_POINT:  r_corner <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together; hold all while the
    // output ray is not taken.
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en        = !r_vld[LAT-1] || o_ray.ready;
    assign i_smp.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_smp.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: blade choice, r2 rescale and triangle fold
    // ------------------------------------------------------------------
    logic [SB+3:0]            w_r0x9;
    logic [BLADE_W-1:0]       w_blade;
    logic signed [R2_W-1:0]   w_r2x, w_r2f;
    logic signed [R3_W-1:0]   w_r3x, w_r3f;

    always_comb begin
        w_r0x9  = (SB+4)'(i_smp.rand_a) * (SB+4)'(NUM_BLADES);
        w_blade = w_r0x9[SB+3:SB];
        if (w_blade > BLADE_W'(NUM_BLADES - 1)) begin
            w_blade = BLADE_W'(NUM_BLADES - 1);
        end
        w_r2x = $signed({5'b0, i_smp.rand_c}) * $signed(R2_W'(NUM_BLADES))
              - $signed({1'b0, w_blade, {SB{1'b0}}});
        w_r3x = $signed({2'b0, i_smp.rand_d});
        w_r2f = w_r2x;
        w_r3f = w_r3x;
        // fold the sample back into the blade triangle
        if (w_r2x + R2_W'(w_r3x) > R2_W'(ONE)) begin
            w_r2f = R2_W'(ONE) - w_r2x;
            w_r3f = ONE - w_r3x;
        end
    end

    logic [BLADE_W-1:0]     r1_blade;
    logic signed [R2_W-1:0] r1_r2;
    logic signed [R3_W-1:0] r1_r3;
    logic [SW+SB-1:0]       r1_nu, r1_nv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_blade <= w_blade;
            r1_r2    <= w_r2f;
            r1_r3    <= w_r3f;
            r1_nu    <= {i_smp.pixel_x, i_smp.rand_a};
            r1_nv    <= {i_smp.pixel_y, i_smp.rand_b};
        end
    end

    // ------------------------------------------------------------------
    // Screen fractions u, v in Q.16: rounded (pixel + r) / size
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] w_wsz, w_hsz;
    logic [NU_W-1:0]   w_num_u, w_num_v;
    logic [QU_W-1:0]   w_u16, w_v16;

    assign w_wsz   = (r_width == '0) ? SIZE_W'(1) : r_width;
    assign w_hsz   = (r_height == '0) ? SIZE_W'(1) : r_height;
    assign w_num_u = {r1_nu, 16'b0} + (NU_W'(w_wsz) << (SB - 1));
    assign w_num_v = {r1_nv, 16'b0} + (NU_W'(w_hsz) << (SB - 1));

    tlc_udiv #(.NUM_W(NU_W), .DEN_W(DU_W), .QUO_W(QU_W)) u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_u),
        .i_den ({w_wsz, {SB{1'b0}}}),
        .o_quo (w_u16)
    );

    tlc_udiv #(.NUM_W(NU_W), .DEN_W(DU_W), .QUO_W(QU_W)) u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_v),
        .i_den ({w_hsz, {SB{1'b0}}}),
        .o_quo (w_v16)
    );

    // ------------------------------------------------------------------
    // Stages 2..6: lens point and ray origin
    // ------------------------------------------------------------------
    logic signed [PRD_W-1:0] r2_pc0, r2_pc1, r2_ps0, r2_ps1;
    logic signed [XR_W-1:0]  r3_xr, r3_yr;
    logic signed [LX_W-1:0]  r4_lx, r4_ly;
    logic signed [OFF_W-1:0] r5_pr [3];
    logic signed [OFF_W-1:0] r5_pu [3];
    logic signed [CB-1:0]    r6_org [3];
    logic signed [CB-1:0]    w_org [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pc0 <= PRD_W'(cos_lut(r1_blade)) * PRD_W'(r1_r2);
            r2_pc1 <= PRD_W'(cos_lut(r1_blade + BLADE_W'(1))) * PRD_W'(r1_r3);
            r2_ps0 <= PRD_W'(sin_lut(r1_blade)) * PRD_W'(r1_r2);
            r2_ps1 <= PRD_W'(sin_lut(r1_blade + BLADE_W'(1))) * PRD_W'(r1_r3);

            // round half up to Q.16
            r3_xr <= XR_W'((ACC_W'(r2_pc0) + ACC_W'(r2_pc1) + ACC_W'(2 ** (SB - 3)))
                           >>> (SB - 2));
            r3_yr <= XR_W'((ACC_W'(r2_ps0) + ACC_W'(r2_ps1) + ACC_W'(2 ** (SB - 3)))
                           >>> (SB - 2));

            r4_lx <= LX_W'(r3_xr) * LX_W'($signed({1'b0, r_lens}));
            r4_ly <= LX_W'(r3_yr) * LX_W'($signed({1'b0, r_lens}));

            for (int k = 0; k < 3; k++) begin
                r5_pr[k] <= OFF_W'($signed(r_right[k*CB +: CB])) * OFF_W'(r4_lx);
                r5_pu[k] <= OFF_W'($signed(r_up[k*CB +: CB])) * OFF_W'(r4_ly);
            end

            r6_org <= w_org;
        end
    end

    always_comb begin
        logic signed [OS_W-1:0] osum;
        for (int k = 0; k < 3; k++) begin
            osum = OS_W'(((OFF_W+1)'(r5_pr[k]) + (OFF_W+1)'(r5_pu[k])
                          + (OFF_W+1)'(2 ** 23)) >>> 24)
                 + OS_W'($signed(r_cam[k*CB +: CB]));
            if (osum > SAT_HI) begin
                w_org[k] = CB'(SAT_HI);
            end else if (osum < SAT_LO) begin
                w_org[k] = CB'(SAT_LO);
            end else begin
                w_org[k] = CB'(osum);
            end
        end
    end

    // hold the origin until the pixel point catches up
    logic [3*CB-1:0] w_org_a;

    tlc_delay #(.WIDTH(3 * CB), .DEPTH(D_ORG_A)) u_dly_org_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r6_org[2], r6_org[1], r6_org[0]}),
        .o_q   (w_org_a)
    );

    // ------------------------------------------------------------------
    // Pixel point and pointing vector
    // ------------------------------------------------------------------
    logic signed [PU_W-1:0] ra_pu [3];
    logic signed [PU_W-1:0] ra_pv [3];
    logic signed [PT_W-1:0] rb_pt [3];
    logic [D_W-1:0]         rc_mag [3];
    logic [2:0]             rc_neg;
    logic [D_W-1:0]         rd_mag [3];
    logic [2:0]             rd_neg;
    logic [D_W-1:0]         rd_mx;
    logic [D_W-1:0]         re_mag [3];
    logic [2:0]             re_neg;
    logic [POS_W-1:0]       re_pos;
    logic                   re_zero;
    logic [NORM_W-1:0]      rf_norm [3];
    logic [SQ_W-1:0]        rg_sq [3];
    logic [SUMSQ_W-1:0]     rh_sum;

    logic [D_W-1:0]   w_mx;
    logic [POS_W-1:0] w_pos;

    always_comb begin
        w_mx = rc_mag[0];
        if (rc_mag[1] > w_mx) w_mx = rc_mag[1];
        if (rc_mag[2] > w_mx) w_mx = rc_mag[2];
        w_pos = '0;
        for (int i = 0; i < D_W; i++) begin
            if (rd_mx[i]) w_pos = POS_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [D_W-1:0] dk;
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                ra_pu[k] <= PU_W'($signed({1'b0, w_u16})) * PU_W'($signed(r_right[k*CB +: CB]));
                ra_pv[k] <= PU_W'($signed({1'b0, w_v16})) * PU_W'($signed(r_up[k*CB +: CB]));

                rb_pt[k] <= PT_W'(PR_W'((PS_W'(ra_pu[k]) + PS_W'(ra_pv[k]) + PS_W'(2 ** 15))
                                         >>> 16))
                          + PT_W'($signed(r_corner[k*CB +: CB]));

                dk = D_W'(rb_pt[k]) - D_W'($signed(w_org_a[k*CB +: CB]));
                rc_mag[k] <= dk[D_W-1] ? D_W'(-dk) : D_W'(dk);
                rc_neg[k] <= dk[D_W-1];

                rd_mag[k] <= rc_mag[k];
                re_mag[k] <= rd_mag[k];

                // largest component lands in [2^29, 2^30)
                rf_norm[k] <= NORM_W'({re_mag[k], {(NORM_W-1){1'b0}}} >> re_pos);

                rg_sq[k] <= SQ_W'(rf_norm[k]) * SQ_W'(rf_norm[k]);
            end
            rd_neg  <= rc_neg;
            rd_mx   <= w_mx;
            re_neg  <= rd_neg;
            re_pos  <= w_pos;
            re_zero <= (rd_mx == '0);
            rh_sum  <= SUMSQ_W'(rg_sq[0]) + SUMSQ_W'(rg_sq[1]) + SUMSQ_W'(rg_sq[2]);
        end
    end

    // ------------------------------------------------------------------
    // Length and normalized direction
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]   w_len;
    logic [3*NORM_W-1:0] w_norm_d;
    logic [3:0]          w_flag_d;
    logic [3*CB-1:0]     w_org_b;
    logic [DIRQ_W-1:0]   w_q [3];

    tlc_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (rh_sum),
        .o_root (w_len)
    );

    tlc_delay #(.WIDTH(3 * NORM_W), .DEPTH(D_NORM)) u_dly_norm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({rf_norm[2], rf_norm[1], rf_norm[0]}),
        .o_q   (w_norm_d)
    );

    tlc_delay #(.WIDTH(4), .DEPTH(D_FLAG)) u_dly_flag (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({re_zero, re_neg}),
        .o_q   (w_flag_d)
    );

    tlc_delay #(.WIDTH(3 * CB), .DEPTH(D_ORG_B)) u_dly_org_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_org_a),
        .o_q   (w_org_b)
    );

    for (genvar k = 0; k < 3; k++) begin : g_dir
        logic [DIRN_W-1:0] w_num;

        // rounded 16384 * |d| / len
        assign w_num = DIRN_W'({w_norm_d[k*NORM_W +: NORM_W], {DIR_FRAC{1'b0}}})
                     + DIRN_W'(w_len[ROOT_W-1:1]);

        tlc_udiv #(.NUM_W(DIRN_W), .DEN_W(ROOT_W), .QUO_W(DIRQ_W)) u_div_dir (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num),
            .i_den (w_len),
            .o_quo (w_q[k])
        );
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [CB-1:0]    r_o_org [3];
    logic signed [DIR_W-1:0] r_o_dir [3];

    always_ff @(posedge i_clk) begin
        logic signed [DIR_W-1:0] mag;
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_o_org[k] <= $signed(w_org_b[k*CB +: CB]);
                if (w_q[k] > DIRQ_W'(2 ** (DIR_W - 1) - 1)) begin
                    mag = DIR_W'(2 ** (DIR_W - 1) - 1);
                end else begin
                    mag = $signed(w_q[k][DIR_W-1:0]);
                end
                if (w_flag_d[3]) begin
                    r_o_dir[k] <= '0;
                end else begin
                    r_o_dir[k] <= w_flag_d[k] ? -mag : mag;
                end
            end
        end
    end

    assign o_ray.valid    = r_vld[LAT-1];
    assign o_ray.origin_x = r_o_org[0];
    assign o_ray.origin_y = r_o_org[1];
    assign o_ray.origin_z = r_o_org[2];
    assign o_ray.dir_x    = r_o_dir[0];
    assign o_ray.dir_y    = r_o_dir[1];
    assign o_ray.dir_z    = r_o_dir[2];

`ifndef SYNTHESIS
    // an accepted sample enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> r_vld[0])
        else $error("accepted sample did not enter the pipeline");

    // a held ray freezes the whole pipeline
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ray.valid && !o_ray.ready) |=> ($stable(r_vld) && $stable(o_ray.dir_x)))
        else $error("pipeline moved while output stalled");

    // no ray leaves right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ray.valid)
        else $error("ray valid after reset");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Thin-lens ray generator testbench
// Drives pixel samples through the sample channel and checks every ray against
// an in-bench fixed-point model of the lens and direction math or a typed-in
// ray. The run uses a short directed table, then random samples under several
// camera settings with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench import tlc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEF;
    localparam int SB = SAMPLE_BITS_DEF;
    localparam int PB = SCREEN_BITS_DEF;
    localparam int PIPE_LAT = PB + 75;
    localparam int WATCH_LIMIT = 20000;
    localparam int N_RANDOM = 1600;

    typedef struct {
        logic [PB-1:0] px, py;
        logic [SB-1:0] ra, rb, rc, rd;
    } t_sample;

    typedef struct {
        logic signed [CB-1:0] ox, oy, oz;
        logic signed [DIR_W-1:0] dx, dy, dz;
    } t_ray;

    // directed row: sample, optional typed-in ray
    typedef struct {
        t_sample s;
        bit      fixed;
        t_ray    r;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    tlc_smp_if smp ();
    tlc_ray_if ray ();

    thin_lens_camera_ray_generator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_smp(smp.sink), .o_ray(ray.source)
    );

    always #2 i_clk = ~i_clk;

    // camera registers as the model sees them
    logic [REG_W-1:0] cam_pos, rgt, upv, corner;
    logic [LENS_W-1:0] lens;
    logic [SIZE_W-1:0] scr_w, scr_h;

    t_ray expected_rays[$];
    int errors = 0;
    int rays_seen = 0;
    int idle_cycles = 0;
    bit long_stall = 0;

    function automatic longint coord_of(logic [REG_W-1:0] r, int k);
        logic signed [CB-1:0] f;
        f = r[k*CB +: CB];
        return longint'(f);
    endfunction

    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint pixel_frac(longint pix, longint r, longint size);
        longint unsigned den, num;
        if (size == 0) size = 1;
        den = longint'(size) << SB;
        num = ((longint'(pix) << SB) + r) << 16;
        return longint'((num + den / 2) / den);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_ray trace_ray(t_sample s);
        longint cos_t[10], sin_t[10];
        longint one, r2, r3, xr, yr, u16, v16, rcomp, ucomp, off, org, pt;
        longint d[3], org_v[3];
        longint unsigned mag[3], mx, sum, len, c;
        int blade;
        t_ray o;
        cos_t = '{16384, 12551, 2845, -8192, -15396, -15396, -8192, 2845, 12551, 16384};
        sin_t = '{0, 10531, 16135, 14189, 5604, -5604, -14189, -16135, -10531, 0};
        one = longint'(1) << SB;
        blade = int'((longint'(s.ra) * NUM_BLADES) >> SB);
        if (blade > NUM_BLADES - 1) blade = NUM_BLADES - 1;
        r2 = longint'(s.rc) * NUM_BLADES - longint'(blade) * one;
        r3 = longint'(s.rd);
        // fold into the blade triangle
        if (r2 + r3 > one) begin
            r2 = one - r2;
            r3 = one - r3;
        end
        xr = round_shr(cos_t[blade] * r2 + cos_t[blade+1] * r3, SB - 2);
        yr = round_shr(sin_t[blade] * r2 + sin_t[blade+1] * r3, SB - 2);
        u16 = pixel_frac(s.px, s.ra, scr_w);
        v16 = pixel_frac(s.py, s.rb, scr_h);
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            rcomp = coord_of(rgt, k);
            ucomp = coord_of(upv, k);
            off = (rcomp * xr + ucomp * yr) * longint'(lens);
            org = coord_of(cam_pos, k) + round_shr(off, 24);
            if (org > (longint'(1) << (CB-1)) - 1) org = (longint'(1) << (CB-1)) - 1;
            if (org < -(longint'(1) << (CB-1))) org = -(longint'(1) << (CB-1));
            pt = coord_of(corner, k) + round_shr(u16 * rcomp + v16 * ucomp, 16);
            org_v[k] = org;
            d[k] = pt - org;
            mag[k] = d[k] < 0 ? longint'(-d[k]) : longint'(d[k]);
            if (mag[k] > mx) mx = mag[k];
        end
        o.ox = org_v[0][CB-1:0];
        o.oy = org_v[1][CB-1:0];
        o.oz = org_v[2][CB-1:0];
        o.dx = '0; o.dy = '0; o.dz = '0;
        if (mx != 0) begin
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int k = 0; k < 3; k++) mag[k] >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx <<= 1;
                for (int k = 0; k < 3; k++) mag[k] <<= 1;
            end
            sum = 0;
            for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
            len = root_floor(sum);
            for (int k = 0; k < 3; k++) begin
                logic signed [DIR_W-1:0] q;
                c = (mag[k] * 16384 + len / 2) / len;
                if (c > 32767) c = 32767;
                q = d[k] < 0 ? -$signed(c[DIR_W-1:0]) : $signed(c[DIR_W-1:0]);
                if (k == 0) o.dx = q; else if (k == 1) o.dy = q; else o.dz = q;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at ray %0d: %s got %0d expected %0d", rays_seen, what, got, want);
        errors++;
    endtask

    // drive one register write at the falling edge, then let it land
    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CAMERA_POS:    cam_pos = val;
            CFG_LENS_SIZE:     lens = val[LENS_W-1:0];
            CFG_RIGHT_VEC:     rgt = val;
            CFG_UP_VEC:        upv = val;
            CFG_CORNER_POINT:  corner = val;
            CFG_SCREEN_WIDTH:  scr_w = val[SIZE_W-1:0];
            CFG_SCREEN_HEIGHT: scr_h = val[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [REG_W-1:0] pack3(int x, int y, int z);
        logic [REG_W-1:0] v;
        v[CB-1:0] = x[CB-1:0];
        v[2*CB-1:CB] = y[CB-1:0];
        v[3*CB-1:2*CB] = z[CB-1:0];
        return v;
    endfunction

    // drop the sample valid, hold until the pipe drains, then let it settle
    task automatic drain();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        while (expected_rays.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 10) @(negedge i_clk);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    // push one sample transaction; valid stays high after acceptance until
    // the next falling edge decides between a gap and the next sample
    task automatic send_sample(t_sample s);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g != 0) begin
            smp.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.pixel_x <= s.px; smp.pixel_y <= s.py;
        smp.rand_a <= s.ra; smp.rand_b <= s.rb;
        smp.rand_c <= s.rc; smp.rand_d <= s.rd;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        s.px = PB'($urandom); s.py = PB'($urandom);
        s.ra = SB'($urandom); s.rb = SB'($urandom);
        s.rc = SB'($urandom); s.rd = SB'($urandom);
        return s;
    endfunction

    function automatic logic [REG_W-1:0] rand_vec(int span);
        return pack3($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                     $urandom_range(2*span) - span);
    endfunction

    // typed-in rows are paired with their expectation at acceptance
    t_row table_rows[$];
    int row_now = -1;

    // record the expectation at each accepted sample transaction
    always @(posedge i_clk) begin
        if (i_rst_n && smp.valid && smp.ready) begin
            t_sample s;
            t_ray r;
            s.px = smp.pixel_x; s.py = smp.pixel_y;
            s.ra = smp.rand_a; s.rb = smp.rand_b; s.rc = smp.rand_c; s.rd = smp.rand_d;
            r = trace_ray(s);
            if (row_now >= 0 && table_rows[row_now].fixed) r = table_rows[row_now].r;
            expected_rays.push_back(r);
        end
    end

    // compare each accepted ray transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && ray.valid && ray.ready) begin
            t_ray w;
            if (expected_rays.size() == 0) begin
                $display("unexpected ray %0d", rays_seen);
                errors++;
            end else begin
                w = expected_rays.pop_front();
                if (ray.origin_x !== w.ox) report_mismatch("origin_x", ray.origin_x, w.ox);
                if (ray.origin_y !== w.oy) report_mismatch("origin_y", ray.origin_y, w.oy);
                if (ray.origin_z !== w.oz) report_mismatch("origin_z", ray.origin_z, w.oz);
                if (ray.dir_x !== w.dx) report_mismatch("dir_x", ray.dir_x, w.dx);
                if (ray.dir_y !== w.dy) report_mismatch("dir_y", ray.dir_y, w.dy);
                if (ray.dir_z !== w.dz) report_mismatch("dir_z", ray.dir_z, w.dz);
            end
            rays_seen++;
        end
    end

    // receiver: random gaps, one long hold-off when asked
    initial begin
        ray.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                ray.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                long_stall = 0;
            end
            ray.ready <= 1'b1;
            @(negedge i_clk);
            if ($urandom_range(3) == 0) begin
                ray.ready <= 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (ray.valid && ray.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_row row;
        smp.valid = 1'b0;
        smp.pixel_x = '0; smp.pixel_y = '0;
        smp.rand_a = '0; smp.rand_b = '0; smp.rand_c = '0; smp.rand_d = '0;
        cam_pos = '0; rgt = '0; upv = '0; corner = '0; lens = '0; scr_w = 1; scr_h = 1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset every vector is zero: zero origin and zero direction
        row.fixed = 1;
        row.r = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0};
        row.s = '{px: 0, py: 0, ra: 0, rb: 0, rc: 0, rd: 0};
        table_rows.push_back(row);
        row.s = '{px: '1, py: '1, ra: '1, rb: '1, rc: '1, rd: '1};
        table_rows.push_back(row);
        // predicted rows: blade edges, fold, out-of-range r2, extremes
        row.fixed = 0;
        row.s = '{px: 0, py: 0, ra: 0, rb: 0, rc: 16'hFFFF, rd: 16'hFFFF};
        table_rows.push_back(row);
        row.s = '{px: 12'hFFF, py: 0, ra: 16'h7282, rb: 16'h8000, rc: 0, rd: 0};
        table_rows.push_back(row);
        row.s = '{px: 0, py: 12'hFFF, ra: 16'hE38E, rb: 16'hFFFF, rc: 16'h1000, rd: 16'hF000};
        table_rows.push_back(row);
        row.s = '{px: 100, py: 200, ra: 16'h8000, rb: 0, rc: 16'h8000, rd: 16'h0100};
        table_rows.push_back(row);
        row.s = '{px: 7, py: 9, ra: 16'h1C72, rb: 16'h1234, rc: 0, rd: 16'hFFFF};
        table_rows.push_back(row);
        for (int b = 0; b < NUM_BLADES; b++) begin
            row.s = '{px: b, py: b, ra: 16'(b * 7282 + 100), rb: 16'hAAAA,
                      rc: 16'(b * 7282 + 3000), rd: 16'h5555};
            table_rows.push_back(row);
        end

        // directed part: reset config first, then extremes
        for (int i = 0; i < table_rows.size(); i++) begin
            if (i == 2) begin
                drain();
                write_reg(CFG_CAMERA_POS, pack3(524287, -524288, 1000));
                write_reg(CFG_LENS_SIZE, REG_W'(16'hFFFF));
                write_reg(CFG_RIGHT_VEC, pack3(-524288, 524287, 0));
                write_reg(CFG_UP_VEC, pack3(524287, 524287, -524288));
                write_reg(CFG_CORNER_POINT, pack3(-524288, 0, 524287));
                write_reg(CFG_SCREEN_WIDTH, REG_W'(0));
                write_reg(CFG_SCREEN_HEIGHT, REG_W'(13'h1FFF));
            end
            row_now = i;
            send_sample(table_rows[i].s);
        end
        drain();
        row_now = -1;

        // random part in phases with several camera settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph % 4)
                0: begin
                    write_reg(CFG_LENS_SIZE, REG_W'(16'h0100));
                    write_reg(CFG_SCREEN_WIDTH, REG_W'(640));
                    write_reg(CFG_SCREEN_HEIGHT, REG_W'(480));
                end
                1: begin
                    write_reg(CFG_LENS_SIZE, REG_W'($urandom));
                    write_reg(CFG_SCREEN_WIDTH, REG_W'(4096));
                    write_reg(CFG_SCREEN_HEIGHT, REG_W'(1));
                end
                2: begin
                    write_reg(CFG_LENS_SIZE, REG_W'(0));
                    write_reg(CFG_SCREEN_WIDTH, REG_W'($urandom_range(4096, 1)));
                    write_reg(CFG_SCREEN_HEIGHT, REG_W'($urandom_range(4096, 1)));
                end
                default: begin
                    write_reg(CFG_LENS_SIZE, REG_W'($urandom));
                    write_reg(CFG_SCREEN_WIDTH, REG_W'($urandom));
                    write_reg(CFG_SCREEN_HEIGHT, REG_W'($urandom));
                end
            endcase
            write_reg(CFG_CAMERA_POS,
                      ph == 7 ? REG_W'({$urandom, $urandom}) : rand_vec(5000));
            write_reg(CFG_RIGHT_VEC,
                      ph == 7 ? REG_W'({$urandom, $urandom}) : rand_vec(4000));
            write_reg(CFG_UP_VEC,
                      ph == 7 ? REG_W'({$urandom, $urandom}) : rand_vec(3000));
            write_reg(CFG_CORNER_POINT,
                      ph == 7 ? REG_W'({$urandom, $urandom}) : rand_vec(8000));
            if (ph == 3) long_stall = 1;
            for (int i = 0; i < N_RANDOM / 8; i++) send_sample(rand_sample());
        end
        drain();

        $display("covered %0d rays: directed extremes, every blade, fold and reset rows,",
                 rays_seen);
        $display("random samples under eight camera settings with gaps and one long stall");
        if (errors == 0 && expected_rays.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
